// File: src/ara_pkg.sv
`timescale 1ns / 1ps
// ============================================================================
// ara_pkg
// Shared types, codes and defaults of the address range allocator.
// ============================================================================
package ara_pkg;

    localparam int ADDR_W         = 32;
    localparam int SLOTS_DEF      = 64;
    localparam int PAGE_BYTES_DEF = 4096;

    localparam logic [1:0] REQ_ADD   = 2'd0;
    localparam logic [1:0] REQ_ALLOC = 2'd1;
    localparam logic [1:0] REQ_CLAIM = 2'd2;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_ZERO = 2'd1;
    localparam logic [1:0] STAT_MISS = 2'd2;
    localparam logic [1:0] STAT_FULL = 2'd3;

    typedef struct packed {
        logic [ADDR_W-1:0] start;
        logic [ADDR_W-1:0] length;
    } t_slot;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ROUND,
        ST_SCAN,
        ST_FSCAN,
        ST_WTAIL,
        ST_WHOLD,
        ST_DONE
    } t_state;

endpackage

// File: src/ara_req_if.sv
`timescale 1ns / 1ps
// ============================================================================
// ara_req_if
// Request channel: valid/ready handshake with the request word.
// ============================================================================
interface ara_req_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic                      pool;
    logic [ara_pkg::ADDR_W-1:0] base_addr;
    logic [ara_pkg::ADDR_W-1:0] byte_len;

    modport source (output valid, output req_type, output pool, output base_addr,
                    output byte_len, input ready);
    modport sink   (input valid, input req_type, input pool, input base_addr,
                    input byte_len, output ready);
endinterface

// File: src/ara_res_if.sv
`timescale 1ns / 1ps
// ============================================================================
// ara_res_if
// Result channel: valid/ready handshake with the result word.
// ============================================================================
interface ara_res_if;
    logic                      valid;
    logic                      ready;
    logic [1:0]                status;
    logic [ara_pkg::ADDR_W-1:0] granted_addr;
    logic [ara_pkg::ADDR_W-1:0] granted_len;
    logic                      cacheable;
    logic                      tail_lost;

    modport source (output valid, output status, output granted_addr,
                    output granted_len, output cacheable, output tail_lost,
                    input ready);
    modport sink   (input valid, input status, input granted_addr,
                    input granted_len, input cacheable, input tail_lost,
                    output ready);
endinterface

// File: src/address_range_allocator.sv
`timescale 1ns / 1ps
// ============================================================================
// address_range_allocator
// First-fit allocator over a RAM and an IO table of free address ranges.
// ============================================================================
// After reset the block clears every slot of both tables and takes no
// request until that pass ends. Requests are handled one at a time: each
// table lives in a memory with a single read port, so a request scans slots
// one per cycle. An add scans up to SLOTS slots before its result word.
// Allocate and claim first round the length up to whole pages, then
// scan up to SLOTS slots; a claim whose right remainder needs a free slot not
// seen before the holding slot scans on past it and writes two slots if it
// finds one. The result waits in an output register, so the next request is
// taken while it is still pending; a stalled result holds the following
// request in its done state until the register frees.
module address_range_allocator #(
    parameter int SLOTS      = ara_pkg::SLOTS_DEF,
    parameter int PAGE_BYTES = ara_pkg::PAGE_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ara_req_if.sink   i_req,
    ara_res_if.source o_res
);

    localparam int IW = $clog2(SLOTS);
    localparam int AW = ara_pkg::ADDR_W;
    localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

    ara_pkg::t_state r_state, n_state;

    logic [1:0]    r_kind, n_kind;
    logic          r_sel_io, n_sel_io;
    logic [AW-1:0] r_addr, n_addr;
    logic [AW-1:0] r_blen, n_blen;
    logic [AW:0]   r_need, n_need;
    logic [AW:0]   r_want_end, n_want_end;
    logic [IW-1:0] r_rd_idx, n_rd_idx;
    logic          r_chk_valid, n_chk_valid;
    logic [IW-1:0] r_chk_idx, n_chk_idx;
    logic          r_ff_valid, n_ff_valid;
    logic [IW-1:0] r_ff_idx, n_ff_idx;
    logic [IW-1:0] r_hold_idx, n_hold_idx;
    logic [AW-1:0] r_hold_start, n_hold_start;
    logic [AW-1:0] r_tail_len, n_tail_len;
    logic [IW-1:0] r_clr_idx, n_clr_idx;

    logic [1:0]    r_res_status, n_res_status;
    logic [AW-1:0] r_res_addr, n_res_addr;
    logic [AW-1:0] r_res_len, n_res_len;
    logic          r_res_cache, n_res_cache;
    logic          r_res_lost, n_res_lost;

    logic          r_out_valid, n_out_valid;
    logic [1:0]    r_out_status;
    logic [AW-1:0] r_out_addr;
    logic [AW-1:0] r_out_len;
    logic          r_out_cache;
    logic          r_out_lost;
    logic          out_load;

    logic           ram_wr_en, io_wr_en;
    logic [IW-1:0]  wr_idx, rd_idx;
    ara_pkg::t_slot wr_data, ram_rd, io_rd, cur;

    logic          round_start, round_done;
    logic [AW:0]   round_need;

    logic          hit;
    logic [AW:0]   cur_end;
    logic [AW-1:0] new_len;

    ara_table #(.SLOTS(SLOTS)) u_ram (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .i_rd_idx  (rd_idx),
        .o_rd_data (ram_rd)
    );

    ara_table #(.SLOTS(SLOTS)) u_io (
        .i_clk     (i_clk),
        .i_wr_en   (io_wr_en),
        .i_wr_idx  (wr_idx),
        .i_wr_data (wr_data),
        .i_rd_idx  (rd_idx),
        .o_rd_data (io_rd)
    );

    ara_round #(.PAGE_BYTES(PAGE_BYTES)) u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (round_start),
        .i_len   (i_req.byte_len),
        .o_done  (round_done),
        .o_need  (round_need)
    );

    assign cur     = r_sel_io ? io_rd : ram_rd;
    assign cur_end = {1'b0, cur.start} + {1'b0, cur.length};
    assign new_len = cur.length - r_need[AW-1:0];

    always_comb begin
        n_state      = r_state;
        n_kind       = r_kind;
        n_sel_io     = r_sel_io;
        n_addr       = r_addr;
        n_blen       = r_blen;
        n_need       = r_need;
        n_want_end   = r_want_end;
        n_rd_idx     = r_rd_idx;
        n_chk_valid  = r_chk_valid;
        n_chk_idx    = r_chk_idx;
        n_ff_valid   = r_ff_valid;
        n_ff_idx     = r_ff_idx;
        n_hold_idx   = r_hold_idx;
        n_hold_start = r_hold_start;
        n_tail_len   = r_tail_len;
        n_clr_idx    = r_clr_idx;
        n_res_status = r_res_status;
        n_res_addr   = r_res_addr;
        n_res_len    = r_res_len;
        n_res_cache  = r_res_cache;
        n_res_lost   = r_res_lost;
        n_out_valid  = r_out_valid && !o_res.ready;
        out_load     = 1'b0;
        i_req.ready  = 1'b0;
        round_start  = 1'b0;
        ram_wr_en    = 1'b0;
        io_wr_en     = 1'b0;
        wr_idx       = r_chk_idx;
        wr_data      = '0;
        rd_idx       = r_rd_idx;
        hit          = 1'b0;

        case (r_state)
            ara_pkg::ST_CLEAR: begin
                ram_wr_en = 1'b1;
                io_wr_en  = 1'b1;
                wr_idx    = r_clr_idx;
                n_clr_idx = IW'(r_clr_idx + 1'b1);
                if (r_clr_idx == LAST) begin
                    n_state = ara_pkg::ST_IDLE;
                end
            end
            ara_pkg::ST_IDLE: begin
                i_req.ready = 1'b1;
                if (i_req.valid) begin
                    n_kind       = i_req.req_type;
                    n_addr       = i_req.base_addr;
                    n_blen       = i_req.byte_len;
                    n_rd_idx     = '0;
                    n_chk_valid  = 1'b0;
                    n_ff_valid   = 1'b0;
                    n_res_status = ara_pkg::STAT_MISS;
                    n_res_addr   = '0;
                    n_res_len    = '0;
                    n_res_cache  = 1'b0;
                    n_res_lost   = 1'b0;
                    case (i_req.req_type)
                        ara_pkg::REQ_ADD: begin
                            n_sel_io = i_req.pool;
                            if (i_req.byte_len == '0) begin
                                n_res_status = ara_pkg::STAT_ZERO;
                                n_state      = ara_pkg::ST_DONE;
                            end else begin
                                n_state = ara_pkg::ST_SCAN;
                            end
                        end
                        ara_pkg::REQ_ALLOC: begin
                            n_sel_io    = 1'b0;
                            round_start = 1'b1;
                            n_state     = ara_pkg::ST_ROUND;
                        end
                        ara_pkg::REQ_CLAIM: begin
                            n_sel_io    = 1'b1;
                            round_start = 1'b1;
                            n_state     = ara_pkg::ST_ROUND;
                        end
                        default: begin
                            n_state = ara_pkg::ST_DONE;
                        end
                    endcase
                end
            end
            ara_pkg::ST_ROUND: begin
                if (round_done) begin
                    n_need     = round_need;
                    n_want_end = {1'b0, r_addr} + round_need;
                    if (round_need == '0) begin
                        n_res_status = ara_pkg::STAT_ZERO;
                        n_state      = ara_pkg::ST_DONE;
                    end else if (round_need[AW]) begin
                        n_state = ara_pkg::ST_DONE;
                    end else begin
                        n_state = ara_pkg::ST_SCAN;
                    end
                end
            end
            ara_pkg::ST_SCAN: begin
                n_rd_idx    = (r_rd_idx == LAST) ? r_rd_idx : IW'(r_rd_idx + 1'b1);
                n_chk_valid = 1'b1;
                n_chk_idx   = r_rd_idx;
                if (r_chk_valid) begin
                    case (r_kind)
                        ara_pkg::REQ_ADD: begin
                            hit = (cur.length == '0);
                            if (hit) begin
                                ram_wr_en    = !r_sel_io;
                                io_wr_en     = r_sel_io;
                                wr_data      = '{start: r_addr, length: r_blen};
                                n_res_status = ara_pkg::STAT_OK;
                                n_state      = ara_pkg::ST_DONE;
                            end
                        end
                        ara_pkg::REQ_ALLOC: begin
                            hit = ({1'b0, cur.length} >= r_need);
                            if (hit) begin
                                ram_wr_en    = 1'b1;
                                wr_data      = '{start: cur.start, length: new_len};
                                n_res_status = ara_pkg::STAT_OK;
                                n_res_addr   = cur.start + new_len;
                                n_res_len    = r_need[AW-1:0];
                                n_res_cache  = 1'b1;
                                n_state      = ara_pkg::ST_DONE;
                            end
                        end
                        default: begin
                            hit = (cur.start <= r_addr) && (r_want_end <= cur_end);
                            if ((cur.length == '0) && !r_ff_valid) begin
                                n_ff_valid = 1'b1;
                                n_ff_idx   = r_chk_idx;
                            end
                            if (hit) begin
                                n_hold_idx   = r_chk_idx;
                                n_hold_start = cur.start;
                                n_tail_len   = AW'(cur_end - r_want_end);
                                if (r_want_end < cur_end) begin
                                    if (r_ff_valid) begin
                                        n_state = ara_pkg::ST_WTAIL;
                                    end else if (r_chk_idx == LAST) begin
                                        n_res_lost = 1'b1;
                                        n_state    = ara_pkg::ST_WHOLD;
                                    end else begin
                                        n_rd_idx    = IW'(r_chk_idx + 1'b1);
                                        n_chk_valid = 1'b0;
                                        n_state     = ara_pkg::ST_FSCAN;
                                    end
                                end else begin
                                    n_state = ara_pkg::ST_WHOLD;
                                end
                            end
                        end
                    endcase
                    if (!hit && (r_chk_idx == LAST)) begin
                        n_res_status = (r_kind == ara_pkg::REQ_ADD) ? ara_pkg::STAT_FULL
                                                                    : ara_pkg::STAT_MISS;
                        n_state      = ara_pkg::ST_DONE;
                    end
                end
            end
            ara_pkg::ST_FSCAN: begin
                n_rd_idx    = (r_rd_idx == LAST) ? r_rd_idx : IW'(r_rd_idx + 1'b1);
                n_chk_valid = 1'b1;
                n_chk_idx   = r_rd_idx;
                if (r_chk_valid) begin
                    if (cur.length == '0) begin
                        n_ff_idx = r_chk_idx;
                        n_state  = ara_pkg::ST_WTAIL;
                    end else if (r_chk_idx == LAST) begin
                        n_res_lost = 1'b1;
                        n_state    = ara_pkg::ST_WHOLD;
                    end
                end
            end
            ara_pkg::ST_WTAIL: begin
                io_wr_en = 1'b1;
                wr_idx   = r_ff_idx;
                wr_data  = '{start: r_want_end[AW-1:0], length: r_tail_len};
                n_state  = ara_pkg::ST_WHOLD;
            end
            ara_pkg::ST_WHOLD: begin
                io_wr_en     = 1'b1;
                wr_idx       = r_hold_idx;
                wr_data      = '{start: r_hold_start, length: r_addr - r_hold_start};
                n_res_status = ara_pkg::STAT_OK;
                n_res_addr   = r_addr;
                n_res_len    = r_need[AW-1:0];
                n_state      = ara_pkg::ST_DONE;
            end
            ara_pkg::ST_DONE: begin
                if (!r_out_valid || o_res.ready) begin
                    out_load    = 1'b1;
                    n_out_valid = 1'b1;
                    n_state     = ara_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = ara_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ara_pkg::ST_CLEAR;
            r_clr_idx   <= '0;
            r_rd_idx    <= '0;
            r_chk_valid <= 1'b0;
            r_ff_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr_idx   <= n_clr_idx;
            r_rd_idx    <= n_rd_idx;
            r_chk_valid <= n_chk_valid;
            r_ff_valid  <= n_ff_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind       <= n_kind;
        r_sel_io     <= n_sel_io;
        r_addr       <= n_addr;
        r_blen       <= n_blen;
        r_need       <= n_need;
        r_want_end   <= n_want_end;
        r_chk_idx    <= n_chk_idx;
        r_ff_idx     <= n_ff_idx;
        r_hold_idx   <= n_hold_idx;
        r_hold_start <= n_hold_start;
        r_tail_len   <= n_tail_len;
        r_res_status <= n_res_status;
        r_res_addr   <= n_res_addr;
        r_res_len    <= n_res_len;
        r_res_cache  <= n_res_cache;
        r_res_lost   <= n_res_lost;
        if (out_load) begin
            r_out_status <= r_res_status;
            r_out_addr   <= r_res_addr;
            r_out_len    <= r_res_len;
            r_out_cache  <= r_res_cache;
            r_out_lost   <= r_res_lost;
        end
    end

    assign o_res.valid        = r_out_valid;
    assign o_res.status       = r_out_status;
    assign o_res.granted_addr = r_out_addr;
    assign o_res.granted_len  = r_out_len;
    assign o_res.cacheable    = r_out_cache;
    assign o_res.tail_lost    = r_out_lost;

    a_fail_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && (o_res.status != ara_pkg::STAT_OK)) |->
        ((o_res.granted_addr == '0) && (o_res.granted_len == '0)
         && !o_res.cacheable && !o_res.tail_lost))
        else $error("failed result carries nonzero fields");

    a_ok_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.cacheable) |->
        ((o_res.status == ara_pkg::STAT_OK) && !o_res.tail_lost
         && (o_res.granted_len != '0)))
        else $error("RAM grant without ok status or with zero length");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> !i_req.ready)
        else $error("request taken while another is in flight");

    a_dual_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ram_wr_en && io_wr_en) |-> (r_state == ara_pkg::ST_CLEAR))
        else $error("both tables written outside the clearing pass");

endmodule

// File: src/ara_table.sv
`timescale 1ns / 1ps
// ============================================================================
// ara_table
// Slot table memory: one write port, one read port with registered data.
// ============================================================================
module ara_table #(
    parameter int SLOTS = ara_pkg::SLOTS_DEF
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(SLOTS)-1:0] i_wr_idx,
    input  ara_pkg::t_slot           i_wr_data,
    input  logic [$clog2(SLOTS)-1:0] i_rd_idx,
    output ara_pkg::t_slot           o_rd_data
);

    ara_pkg::t_slot r_mem [SLOTS];
    ara_pkg::t_slot r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_idx] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_data <= r_mem[i_rd_idx];
    end

    assign o_rd_data = r_rd_data;

endmodule

// File: src/ara_round.sv
`timescale 1ns / 1ps
// ============================================================================
// ara_round
// Page rounding unit: reciprocal multiply for the page remainder, then round up.
// ============================================================================
module ara_round #(
    parameter int PAGE_BYTES = ara_pkg::PAGE_BYTES_DEF
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [ara_pkg::ADDR_W-1:0] i_len,
    output logic                       o_done,
    output logic [ara_pkg::ADDR_W:0]   o_need
);

    localparam int AW = ara_pkg::ADDR_W;
    localparam int RW = $clog2(PAGE_BYTES) + 1;
    localparam int SH = AW + $clog2(PAGE_BYTES);
    localparam logic [63:0]   MAGIC_W = ((64'd1 << SH) / 64'(PAGE_BYTES)) + 64'd1;
    localparam logic [AW:0]   MAGIC   = MAGIC_W[AW:0];
    localparam logic [AW-1:0] PAGE_A  = AW'(PAGE_BYTES);
    localparam logic [AW:0]   PAGE_N  = (AW + 1)'(PAGE_BYTES);

    logic          r_orig_v, r_quot_v, r_done;
    logic [AW-1:0] r_orig;
    logic [AW-1:0] r_quot;
    logic [RW-1:0] r_rem;
    logic [2*AW:0] prod;
    logic [AW-1:0] quot;
    logic [AW-1:0] rem_full;

    // quotient by the page size: multiply by the rounded-up reciprocal, shift
    assign prod     = {{AW{1'b0}}, MAGIC} * {{(AW + 1){1'b0}}, r_orig};
    assign quot     = AW'(prod >> SH);
    assign rem_full = r_orig - r_quot * PAGE_A;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orig_v <= 1'b0;
            r_quot_v <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_orig_v <= i_start;
            r_quot_v <= r_orig_v;
            r_done   <= r_quot_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_orig <= i_len;
        end
        r_quot <= quot;
        r_rem  <= RW'(rem_full);
    end

    assign o_done = r_done;
    assign o_need = {1'b0, r_orig}
                  + ((r_rem == '0) ? '0 : (PAGE_N - (AW + 1)'(r_rem)));

endmodule
